/* rtl/bale_pkg.sv */
// Package for the bounded array list engine.
// Holds opcode and status codes and the fixed field widths of both streams.
// No dependencies.
package bale_pkg;

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - STATUS_W - DATA_W - LEN_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_GET    = 3'd0,
        OP_SET    = 3'd1,
        OP_APPEND = 3'd2,
        OP_INSERT = 3'd3,
        OP_DELETE = 3'd4
    } bale_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_FULL   = 2'd2
    } bale_status_t;

endpackage

/* rtl/bounded_array_list_engine.sv */
// Top level of the bounded array list engine.
// Elements live in one synchronous memory; a sequencer shifts them on insert and delete.
// Depends on bale_pkg.
//
//  channel | dir | handshake          | payload, lowest bit first
//  --------+-----+--------------------+--------------------------------------------
//  s_      | in  | s_tvalid, s_tready | s_tdata: opcode[2:0] position[10:3] value[42:11]
//  m_      | out | m_tvalid, m_tready | m_tdata: status[1:0] read_data[33:2] length[38:34]
//
// On the way to the internal result slot, set, append, refused and unknown operations finish
// on acceptance; get passes GET_WAIT; a shifting insert passes SHIFT, WB_LAST and INS_VAL,
// a shifting delete SHIFT and WB_LAST. The single memory read port moves one element per cycle.
// A new transaction is taken once the previous result has left the internal result slot,
// which happens while an earlier result may still wait at the output.
// Reset (aresetn low, synchronous) empties the list; memory contents are not cleared.
module bounded_array_list_engine
    import bale_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // opcode[2:0], position[10:3], value[42:11], zero[47:43]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[1:0], read_data[33:2], length[38:34], zero[39]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        IDLE,
        GET_WAIT,
        SHIFT,
        WB_LAST,
        INS_VAL
    } state_t;

    // Element memory with a registered read port.
    logic [DATA_W-1:0] mem [CAPACITY];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [DATA_W-1:0] mem_rdata_reg;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [IDX_W-1:0]  stop_reg, stop_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic              up_reg, up_next;
    logic              wb_valid_reg, wb_valid_next;
    logic [IDX_W-1:0]  wb_addr_reg, wb_addr_next;

    logic                res_valid_reg, res_valid_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [DATA_W-1:0]   res_rdata_reg, res_rdata_next;
    logic [LEN_W-1:0]    res_len_reg, res_len_next;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [DATA_W-1:0]   m_rdata_reg, m_rdata_next;
    logic [LEN_W-1:0]    m_len_reg, m_len_next;

    logic [OPCODE_W-1:0] in_op;
    logic [POS_W-1:0]    in_pos;
    logic [DATA_W-1:0]   in_val;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic [IDX_W-1:0]    pos_idx;
    logic [IDX_W-1:0]    cnt_idx;
    logic                accept;
    logic                full;
    logic                fin;
    logic [STATUS_W-1:0] fin_status;
    logic [DATA_W-1:0]   fin_rdata;

    assign in_op   = s_tdata[OPCODE_W-1:0];
    assign in_pos  = s_tdata[OPCODE_W +: POS_W];
    assign in_val  = s_tdata[OPCODE_W+POS_W +: DATA_W];
    assign pos_ext = CMP_W'(in_pos);
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_idx = in_pos[IDX_W-1:0];
    assign cnt_idx = count_reg[IDX_W-1:0];
    assign full    = (count_reg == CNT_W'(CAPACITY));

    assign s_tready = (state_reg == IDLE) && !res_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_len_reg, m_rdata_reg, m_status_reg};

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        stop_next       = stop_reg;
        val_next        = val_reg;
        up_next         = up_reg;
        wb_valid_next   = wb_valid_reg;
        wb_addr_next    = wb_addr_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        res_rdata_next  = res_rdata_reg;
        res_len_next    = res_len_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_rdata_next    = m_rdata_reg;
        m_len_next      = m_len_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        fin             = 1'b0;
        fin_status      = ST_OK;
        fin_rdata       = '0;

        // Move a finished result into the output register when it is free.
        if (res_valid_reg && (!m_valid_reg || m_tready)) begin
            m_valid_next   = 1'b1;
            m_status_next  = res_status_reg;
            m_rdata_next   = res_rdata_reg;
            m_len_next     = res_len_reg;
            res_valid_next = 1'b0;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            IDLE: begin
                if (accept) begin
                    case (in_op)
                        OP_GET: begin
                            if (pos_ext < cnt_ext) begin
                                mem_re     = 1'b1;
                                mem_raddr  = pos_idx;
                                state_next = GET_WAIT;
                            end else begin
                                fin        = 1'b1;
                                fin_status = ST_BOUNDS;
                            end
                        end
                        OP_SET: begin
                            fin = 1'b1;
                            if (pos_ext < cnt_ext) begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_idx;
                                mem_wdata = in_val;
                            end else begin
                                fin_status = ST_BOUNDS;
                            end
                        end
                        OP_APPEND: begin
                            fin = 1'b1;
                            if (full) begin
                                fin_status = ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = cnt_idx;
                                mem_wdata  = in_val;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_INSERT: begin
                            if (full) begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end else if (pos_ext > cnt_ext) begin
                                fin        = 1'b1;
                                fin_status = ST_BOUNDS;
                            end else if (pos_ext == cnt_ext) begin
                                fin        = 1'b1;
                                mem_we     = 1'b1;
                                mem_waddr  = pos_idx;
                                mem_wdata  = in_val;
                                count_next = count_reg + 1'b1;
                            end else begin
                                // Move elements up, starting at the top one.
                                count_next    = count_reg + 1'b1;
                                rd_ptr_next   = cnt_idx - 1'b1;
                                stop_next     = pos_idx;
                                val_next      = in_val;
                                up_next       = 1'b1;
                                wb_valid_next = 1'b0;
                                state_next    = SHIFT;
                            end
                        end
                        OP_DELETE: begin
                            if (pos_ext >= cnt_ext) begin
                                fin        = 1'b1;
                                fin_status = ST_BOUNDS;
                            end else if (pos_ext == cnt_ext - 1'b1) begin
                                fin        = 1'b1;
                                count_next = count_reg - 1'b1;
                            end else begin
                                // Move elements down, starting just above the hole.
                                count_next    = count_reg - 1'b1;
                                rd_ptr_next   = pos_idx + 1'b1;
                                stop_next     = IDX_W'(count_reg - 1'b1);
                                up_next       = 1'b0;
                                wb_valid_next = 1'b0;
                                state_next    = SHIFT;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            GET_WAIT: begin
                fin        = 1'b1;
                fin_rdata  = mem_rdata_reg;
                state_next = IDLE;
            end
            SHIFT: begin
                // Each write stores the element read in the previous cycle and never targets the
                // address being read in the same cycle.
                if (wb_valid_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = wb_addr_reg;
                    mem_wdata = mem_rdata_reg;
                end
                mem_re        = 1'b1;
                mem_raddr     = rd_ptr_reg;
                wb_valid_next = 1'b1;
                wb_addr_next  = up_reg ? rd_ptr_reg + 1'b1 : rd_ptr_reg - 1'b1;
                if (rd_ptr_reg == stop_reg) begin
                    state_next = WB_LAST;
                end else begin
                    rd_ptr_next = up_reg ? rd_ptr_reg - 1'b1 : rd_ptr_reg + 1'b1;
                end
            end
            WB_LAST: begin
                mem_we        = 1'b1;
                mem_waddr     = wb_addr_reg;
                mem_wdata     = mem_rdata_reg;
                wb_valid_next = 1'b0;
                if (up_reg) begin
                    state_next = INS_VAL;
                end else begin
                    fin        = 1'b1;
                    state_next = IDLE;
                end
            end
            INS_VAL: begin
                mem_we     = 1'b1;
                mem_waddr  = stop_reg;
                mem_wdata  = val_reg;
                fin        = 1'b1;
                state_next = IDLE;
            end
            default: begin
                state_next = IDLE;
            end
        endcase

        if (fin) begin
            res_valid_next  = 1'b1;
            res_status_next = fin_status;
            res_rdata_next  = fin_rdata;
            res_len_next    = LEN_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            wb_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wb_valid_reg  <= wb_valid_next;
            res_valid_reg <= res_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        rd_ptr_reg     <= rd_ptr_next;
        stop_reg       <= stop_next;
        val_reg        <= val_next;
        up_reg         <= up_next;
        wb_addr_reg    <= wb_addr_next;
        res_status_reg <= res_status_next;
        res_rdata_reg  <= res_rdata_next;
        res_len_reg    <= res_len_next;
        m_status_reg   <= m_status_next;
        m_rdata_reg    <= m_rdata_next;
        m_len_reg      <= m_len_next;
    end

endmodule

/* rtl/bale_check.sv */
// Port-level checker for the bounded array list engine, bound to the top level.
// Watches the result stream over time. Depends on bale_pkg.
module bale_check
    import bale_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] out_status;
    logic [DATA_W-1:0]   out_rdata;
    logic [LEN_W-1:0]    out_len;

    assign out_status = m_tdata[STATUS_W-1:0];
    assign out_rdata  = m_tdata[STATUS_W +: DATA_W];
    assign out_len    = m_tdata[STATUS_W+DATA_W +: LEN_W];

    // No result may appear in the cycle after a reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A refused operation never returns data.
    a_err_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_status != ST_OK |-> out_rdata == '0)
        else $error("refused operation returned data");

    // A full refusal reports a list at capacity.
    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_status == ST_FULL |-> out_len == LEN_W'(CAPACITY))
        else $error("full status with list not at capacity");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_status == ST_OK || out_status == ST_BOUNDS ||
                      out_status == ST_FULL))
        else $error("undefined status code");

endmodule

bind bounded_array_list_engine bale_check #(.CAPACITY(CAPACITY)) u_bale_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
